// File: src/sdz_pkg.sv
// Shared types and constants of the stick dead zone scaler.
// Used by the square root cells, the divider cells and the top level.
`default_nettype none

package sdz_pkg;

    // Samples are taken from the low SAMPLE_BITS bits of each field.
    localparam int SAMPLE_BITS = 16;
    // Result bits of the square root, one cell each.
    localparam int ROOT_W = 16;
    // Quotient bits of each division pass, one cell each.
    localparam int QB = 15;
    localparam logic [14:0] Q_ONE = 15'd16384;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_INDEP = 2'd1,
        MODE_CIRC  = 2'd2
    } zone_mode_t;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_DZ   = 2'd1;
    localparam logic [1:0] REG_FS   = 2'd2;

    localparam logic [1:0]  RST_MODE = 2'd1;
    localparam logic [14:0] RST_DZ   = 15'd7849;
    localparam logic [14:0] RST_FS   = 15'd32767;

    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
        logic        ovr_zero;
        logic        ovr_one;
    } lane_t;

    typedef struct packed {
        lane_t       lx;
        lane_t       ly;
        logic        circ;
        logic        zone;
        logic [15:0] r;
    } item_t;

    typedef struct packed {
        logic [31:0] rad;
        logic [17:0] rem;
        logic [15:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] dsr;
        logic [14:0] low;
        logic [14:0] quo;
    } div_st_t;

endpackage

`default_nettype wire

// File: src/sdz_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
// Depends on sdz_pkg for the item and root state types.
`default_nettype none

module sdz_sqrt_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sdz_pkg::item_t   in_item,
    input  wire sdz_pkg::sqrt_st_t in_st,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sdz_pkg::item_t        out_item,
    output sdz_pkg::sqrt_st_t     out_st
);

    logic              valid_reg;
    sdz_pkg::item_t    item_reg;
    sdz_pkg::sqrt_st_t st_reg;
    sdz_pkg::sqrt_st_t st_next;
    logic [19:0]       rem_t;
    logic [19:0]       trial;
    logic              ge;

    // Bring down the next two radicand bits and try the digit one.
    always_comb
    begin
        rem_t = {in_st.rem, in_st.rad[31:30]};
        trial = {2'b00, in_st.root, 2'b01};
        ge    = (rem_t >= trial);
        st_next.rad  = {in_st.rad[29:0], 2'b00};
        st_next.rem  = ge ? 18'(rem_t - trial) : rem_t[17:0];
        st_next.root = {in_st.root[14:0], ge};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_st    = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
            st_reg   <= st_next;
        end
    end

endmodule

`default_nettype wire

// File: src/sdz_div_cell.sv
// One quotient bit cell of the pipelined restoring divider, both axes side by side.
// Depends on sdz_pkg for the item and divider state types.
`default_nettype none

module sdz_div_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sdz_pkg::item_t   in_item,
    input  wire sdz_pkg::div_st_t in_dx,
    input  wire sdz_pkg::div_st_t in_dy,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sdz_pkg::item_t        out_item,
    output sdz_pkg::div_st_t      out_dx,
    output sdz_pkg::div_st_t      out_dy
);

    logic             valid_reg;
    sdz_pkg::item_t   item_reg;
    sdz_pkg::div_st_t dx_reg;
    sdz_pkg::div_st_t dy_reg;
    sdz_pkg::div_st_t dx_next;
    sdz_pkg::div_st_t dy_next;

    function automatic sdz_pkg::div_st_t div_step(input sdz_pkg::div_st_t s);
        sdz_pkg::div_st_t n;
        logic [16:0]      t;
        logic             ge;
        t  = {s.rem, s.low[14]};
        ge = (t >= {1'b0, s.dsr});
        n.rem = ge ? 16'(t - {1'b0, s.dsr}) : t[15:0];
        n.dsr = s.dsr;
        n.low = {s.low[13:0], 1'b0};
        n.quo = {s.quo[13:0], ge};
        return n;
    endfunction

    always_comb
    begin
        dx_next = div_step(in_dx);
        dy_next = div_step(in_dy);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_dx    = dx_reg;
    assign out_dy    = dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
        end
    end

endmodule

`default_nettype wire

// File: src/stick_dead_zone_scaler.sv
// Top level of the stick dead zone scaler: configuration registers and the cell pipeline.
// Depends on sdz_pkg, sdz_sqrt_cell and sdz_div_cell.
`default_nettype none

// Usage:
// A request on the input channel (in_valid/in_ready) carries one raw sample pair
// x_raw, y_raw. The result x_scaled, y_scaled leaves on the output channel
// (out_valid/out_ready) in Q1.14, in the order of the requests.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// zone_mode, dead_zone_size and full_scale; it is always ready and must only be
// used while no request is in flight.
// From acceptance to out_valid a request passes, in every mode, two front
// stages, sixteen square root cells, a dead zone setup stage, fifteen divider
// cells, a multiply stage, fifteen more divider cells and the output register.
// Throughput is one request per cycle while the receiver takes results; each cell
// holds one request and passes it on whenever the next stage is ready.
// When the receiver stalls, requests pile up from the output backwards; in_ready
// only falls once every stage is full. Bubbles are squeezed out meanwhile.
// Reset empties the pipeline and loads mode independent, dead zone 7849 and
// full scale 32767.
module stick_dead_zone_scaler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] x_raw,
    input  wire logic [15:0] y_raw,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      x_scaled,
    output logic [15:0]      y_scaled,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int NS = sdz_pkg::ROOT_W;
    localparam int ND = sdz_pkg::QB;

    typedef struct packed {
        sdz_pkg::lane_t   lane;
        sdz_pkg::div_st_t dv;
    } zs_t;

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [14:0] dz_reg;
    logic [14:0] fs_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sdz_pkg::RST_MODE;
            dz_reg   <= sdz_pkg::RST_DZ;
            fs_reg   <= sdz_pkg::RST_FS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sdz_pkg::REG_MODE: mode_reg <= cfg_data[1:0];
                sdz_pkg::REG_DZ:   dz_reg   <= cfg_data[14:0];
                sdz_pkg::REG_FS:   fs_reg   <= cfg_data[14:0];
                default:           ;
            endcase
        end
    end

    // Front stage: sign extension, magnitudes and squares.
    logic           p0_valid_reg;
    logic           p0_ready;
    sdz_pkg::item_t p0_item_reg;
    sdz_pkg::item_t p0_item_next;
    logic [31:0]    xx_reg;
    logic [31:0]    yy_reg;
    logic [15:0]    xs;
    logic [15:0]    ys;

    always_comb
    begin
        xs = 16'(signed'(x_raw[sdz_pkg::SAMPLE_BITS-1:0]));
        ys = 16'(signed'(y_raw[sdz_pkg::SAMPLE_BITS-1:0]));
        p0_item_next          = '0;
        p0_item_next.lx.neg   = xs[15];
        p0_item_next.lx.mag   = xs[15] ? 16'(-xs) : xs;
        p0_item_next.ly.neg   = ys[15];
        p0_item_next.ly.mag   = ys[15] ? 16'(-ys) : ys;
        case (mode_reg)
            sdz_pkg::MODE_INDEP:
            begin
                p0_item_next.zone = 1'b1;
            end
            sdz_pkg::MODE_CIRC:
            begin
                p0_item_next.zone = 1'b1;
                p0_item_next.circ = 1'b1;
            end
            default:
            begin
                p0_item_next.zone = 1'b0;
            end
        endcase
    end

    // Second front stage: sum of squares into the root state.
    logic              p1_valid_reg;
    logic              p1_ready;
    sdz_pkg::item_t    p1_item_reg;
    sdz_pkg::sqrt_st_t p1_st_reg;

    logic              cv [0:NS];
    logic              cr [0:NS];
    sdz_pkg::item_t    c_item [0:NS];
    sdz_pkg::sqrt_st_t c_st [0:NS];

    assign in_ready = p0_ready;
    assign p0_ready = !p0_valid_reg || p1_ready;
    assign p1_ready = !p1_valid_reg || cr[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            if (p0_ready)
                p0_valid_reg <= in_valid;
            if (p1_ready)
                p1_valid_reg <= p0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && p0_ready)
        begin
            p0_item_reg <= p0_item_next;
            xx_reg      <= p0_item_next.lx.mag * p0_item_next.lx.mag;
            yy_reg      <= p0_item_next.ly.mag * p0_item_next.ly.mag;
        end
        if (p0_valid_reg && p1_ready)
        begin
            p1_item_reg <= p0_item_reg;
            p1_st_reg   <= '{rad: 32'(xx_reg + yy_reg), rem: '0, root: '0};
        end
    end

    assign cv[0]     = p1_valid_reg;
    assign c_item[0] = p1_item_reg;
    assign c_st[0]   = p1_st_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        sdz_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_item   (c_item[i]),
            .in_st     (c_st[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_item  (c_item[i+1]),
            .out_st    (c_st[i+1])
        );
    end

    // Dead zone setup: the value is the axis magnitude, or the length when circular.
    function automatic zs_t zone_setup(input sdz_pkg::lane_t ln, input logic [15:0] v,
                                       input logic [14:0] dz, input logic [14:0] fs);
        zs_t         z;
        logic [15:0] span;
        logic [15:0] diff;
        logic        zero;
        logic        one;
        span = {1'b0, fs} - {1'b0, dz};
        diff = v - {1'b0, dz};
        zero = (v <= {1'b0, dz});
        // A dead zone at or above full scale saturates everything outside it.
        one  = !zero && (span[15] || (span == 16'd0) || (diff >= span));
        z.lane          = ln;
        z.lane.ovr_zero = zero;
        z.lane.ovr_one  = one;
        z.dv.rem = (zero || one) ? 16'd0 : diff;
        z.dv.dsr = (zero || one) ? 16'd1 : span;
        z.dv.low = '0;
        z.dv.quo = '0;
        return z;
    endfunction

    logic             z_valid_reg;
    logic             z_ready;
    sdz_pkg::item_t   z_item_reg;
    sdz_pkg::item_t   z_item_next;
    sdz_pkg::div_st_t z_dx_reg;
    sdz_pkg::div_st_t z_dy_reg;
    zs_t              zx_next;
    zs_t              zy_next;
    logic [14:0]      dz_eff;
    logic [15:0]      vx;
    logic [15:0]      vy;

    always_comb
    begin
        dz_eff  = c_item[NS].zone ? dz_reg : 15'd0;
        vx      = c_item[NS].circ ? c_st[NS].root : c_item[NS].lx.mag;
        vy      = c_item[NS].circ ? c_st[NS].root : c_item[NS].ly.mag;
        zx_next = zone_setup(c_item[NS].lx, vx, dz_eff, fs_reg);
        zy_next = zone_setup(c_item[NS].ly, vy, dz_eff, fs_reg);
        z_item_next    = c_item[NS];
        z_item_next.lx = zx_next.lane;
        z_item_next.ly = zy_next.lane;
        z_item_next.r  = c_st[NS].root;
    end

    logic             av [0:ND];
    logic             ar [0:ND];
    sdz_pkg::item_t   a_item [0:ND];
    sdz_pkg::div_st_t a_dx [0:ND];
    sdz_pkg::div_st_t a_dy [0:ND];

    assign cr[NS]  = z_ready;
    assign z_ready = !z_valid_reg || ar[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            z_valid_reg <= 1'b0;
        else if (z_ready)
            z_valid_reg <= cv[NS];
    end

    always_ff @(posedge clk)
    begin
        if (cv[NS] && z_ready)
        begin
            z_item_reg <= z_item_next;
            z_dx_reg   <= zx_next.dv;
            z_dy_reg   <= zy_next.dv;
        end
    end

    assign av[0]     = z_valid_reg;
    assign a_item[0] = z_item_reg;
    assign a_dx[0]   = z_dx_reg;
    assign a_dy[0]   = z_dy_reg;

    for (genvar i = 0; i < ND; i++)
    begin : g_div_a
        sdz_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (av[i]),
            .in_ready  (ar[i]),
            .in_item   (a_item[i]),
            .in_dx     (a_dx[i]),
            .in_dy     (a_dy[i]),
            .out_valid (av[i+1]),
            .out_ready (ar[i+1]),
            .out_item  (a_item[i+1]),
            .out_dx    (a_dx[i+1]),
            .out_dy    (a_dy[i+1])
        );
    end

    // Scale stage. Circular mode divides |axis| * w by the length in the second pass;
    // the other modes pass w through a division by one.
    function automatic sdz_pkg::div_st_t scale_setup(input sdz_pkg::lane_t ln,
                                                     input logic [14:0] quo,
                                                     input logic circ,
                                                     input logic [15:0] r);
        sdz_pkg::div_st_t d;
        logic [14:0]      w;
        logic [30:0]      n;
        if (ln.ovr_zero)
            w = 15'd0;
        else if (ln.ovr_one)
            w = sdz_pkg::Q_ONE;
        else
            w = {1'b0, quo[14:1]};
        n     = circ ? (ln.mag * w) : 31'(w);
        d.rem = 16'(n[29:15]);
        d.low = n[14:0];
        d.dsr = (circ && (r != 16'd0)) ? r : 16'd1;
        d.quo = '0;
        return d;
    endfunction

    logic             f_valid_reg;
    logic             f_ready;
    sdz_pkg::item_t   f_item_reg;
    sdz_pkg::div_st_t f_dx_reg;
    sdz_pkg::div_st_t f_dy_reg;

    logic             bv [0:ND];
    logic             br [0:ND];
    sdz_pkg::item_t   b_item [0:ND];
    sdz_pkg::div_st_t b_dx [0:ND];
    sdz_pkg::div_st_t b_dy [0:ND];

    assign ar[ND]  = f_ready;
    assign f_ready = !f_valid_reg || br[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (f_ready)
            f_valid_reg <= av[ND];
    end

    always_ff @(posedge clk)
    begin
        if (av[ND] && f_ready)
        begin
            f_item_reg <= a_item[ND];
            f_dx_reg   <= scale_setup(a_item[ND].lx, a_dx[ND].quo, a_item[ND].circ,
                                      a_item[ND].r);
            f_dy_reg   <= scale_setup(a_item[ND].ly, a_dy[ND].quo, a_item[ND].circ,
                                      a_item[ND].r);
        end
    end

    assign bv[0]     = f_valid_reg;
    assign b_item[0] = f_item_reg;
    assign b_dx[0]   = f_dx_reg;
    assign b_dy[0]   = f_dy_reg;

    for (genvar i = 0; i < ND; i++)
    begin : g_div_b
        sdz_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (bv[i]),
            .in_ready  (br[i]),
            .in_item   (b_item[i]),
            .in_dx     (b_dx[i]),
            .in_dy     (b_dy[i]),
            .out_valid (bv[i+1]),
            .out_ready (br[i+1]),
            .out_item  (b_item[i+1]),
            .out_dx    (b_dx[i+1]),
            .out_dy    (b_dy[i+1])
        );
    end

    // Output register: apply the signs.
    logic        o_valid_reg;
    logic        o_ready;
    logic [15:0] ox_reg;
    logic [15:0] oy_reg;
    logic [15:0] ox_next;
    logic [15:0] oy_next;

    always_comb
    begin
        ox_next = b_item[ND].lx.neg ? 16'(-{1'b0, b_dx[ND].quo}) : {1'b0, b_dx[ND].quo};
        oy_next = b_item[ND].ly.neg ? 16'(-{1'b0, b_dy[ND].quo}) : {1'b0, b_dy[ND].quo};
    end

    assign br[ND]  = o_ready;
    assign o_ready = !o_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_ready)
            o_valid_reg <= bv[ND];
    end

    always_ff @(posedge clk)
    begin
        if (bv[ND] && o_ready)
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign x_scaled  = ox_reg;
    assign y_scaled  = oy_reg;

    // Results never leave the unit range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(x_scaled) <= 16'sd16384 && $signed(x_scaled) >= -16'sd16384
                    && $signed(y_scaled) <= 16'sd16384 && $signed(y_scaled) >= -16'sd16384))
        else $error("scaled value outside the unit range");

    // Requests are only refused when the pipeline is full behind a stalled receiver.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input refused while the pipeline could advance");

    // An accepted request always lands in the front stage.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> p0_valid_reg)
        else $error("accepted request lost at the front stage");

endmodule

`default_nettype wire
